// ===== hw/rtl/bpe_pkg.sv =====
// Shared types, codes and defaults for the Bezier point evaluator.
package bpe_pkg;

  localparam int MAX_POINTS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int MIN_POINTS      = 2;
  localparam int IDX_W           = 7;
  localparam int COORD_W         = 32;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_T_RANGE    = 2'd1;
  localparam logic [1:0] STAT_FEW_POINTS = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX  = 2'd3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic                      wr_en;
    logic [3:0]                wr_idx;
    logic signed [COORD_W-1:0] wr_x;
    logic signed [COORD_W-1:0] wr_y;
    logic                      load;
    logic                      shift;
    logic [IDX_W-1:0]          wrap_idx;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/bpe_lerp.sv =====
// Rounded linear interpolation between two Q16.16 values for one axis.
module bpe_lerp #(
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic signed [bpe_pkg::COORD_W-1:0] a,
  input  logic signed [bpe_pkg::COORD_W-1:0] b,
  input  logic        [T_FRAC_BITS:0]        t,
  output logic signed [bpe_pkg::COORD_W-1:0] p
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int DW = bpe_pkg::COORD_W + 1;
  localparam int PW = DW + TW + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (T_FRAC_BITS - 1);

  logic signed [DW-1:0] diff;
  logic signed [TW:0]   t_s;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;
  logic signed [PW-1:0] q;

  assign diff = {b[bpe_pkg::COORD_W-1], b} - {a[bpe_pkg::COORD_W-1], a};
  assign t_s  = {1'b0, t};
  assign prod = PW'(diff) * PW'(t_s);
  assign sum  = prod + $signed(HALF);
  assign q    = sum >>> T_FRAC_BITS;
  assign p    = a + q[bpe_pkg::COORD_W-1:0];

endmodule

// ===== hw/rtl/bpe_cell.sv =====
// One ring cell: a stored control point and its working copy.
module bpe_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                               clk,
  input  bpe_pkg::cell_ctl_t                 ctl,
  input  logic signed [bpe_pkg::COORD_W-1:0] right_x,
  input  logic signed [bpe_pkg::COORD_W-1:0] right_y,
  input  logic signed [bpe_pkg::COORD_W-1:0] fb_x,
  input  logic signed [bpe_pkg::COORD_W-1:0] fb_y,
  output logic signed [bpe_pkg::COORD_W-1:0] w_x,
  output logic signed [bpe_pkg::COORD_W-1:0] w_y
);

  logic signed [bpe_pkg::COORD_W-1:0] sx_r;
  logic signed [bpe_pkg::COORD_W-1:0] sy_r;
  logic signed [bpe_pkg::COORD_W-1:0] wx_r;
  logic signed [bpe_pkg::COORD_W-1:0] wy_r;
  logic signed [bpe_pkg::COORD_W-1:0] wx_nxt;
  logic signed [bpe_pkg::COORD_W-1:0] wy_nxt;
  logic                               is_wrap;
  logic                               wr_hit;

  assign is_wrap = (ctl.wrap_idx == bpe_pkg::IDX_W'(CELL_IDX));
  assign wr_hit  = ctl.wr_en &&
                   ({{(bpe_pkg::IDX_W-4){1'b0}}, ctl.wr_idx} == bpe_pkg::IDX_W'(CELL_IDX));

  always_comb begin
    wx_nxt = wx_r;
    wy_nxt = wy_r;
    if (ctl.load) begin
      wx_nxt = sx_r;
      wy_nxt = sy_r;
    end else if (ctl.shift) begin
      wx_nxt = is_wrap ? fb_x : right_x;
      wy_nxt = is_wrap ? fb_y : right_y;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      sx_r <= ctl.wr_x;
      sy_r <= ctl.wr_y;
    end
    wx_r <= wx_nxt;
    wy_r <= wy_nxt;
  end

  assign w_x = wx_r;
  assign w_y = wy_r;

endmodule

// ===== hw/rtl/bezier_point_evaluate.sv =====
// Top level: Bezier point evaluator with a ring of point cells and one interpolator per axis.
//
// A write request stores one control point and a rejected request reports its
// status; both give their result on the cycle after start and never raise
// busy. An evaluate request holds busy while the working ring reduces its n
// active points, and its result appears in the same cycle that busy falls.
// Each de Casteljau level rotates the ring through the single x and y
// interpolators at its head. out_valid is high for exactly one cycle per
// request and the result must be taken then.
module bezier_point_evaluate #(
  parameter int MAX_POINTS  = bpe_pkg::MAX_POINTS_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic [3:0]                         in_index,
  input  logic signed [bpe_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [bpe_pkg::COORD_W-1:0] in_point_y,
  input  logic [T_FRAC_BITS:0]               in_t_param,
  output logic                               out_valid,
  output logic signed [bpe_pkg::COORD_W-1:0] out_result_x,
  output logic signed [bpe_pkg::COORD_W-1:0] out_result_y,
  output logic [1:0]                         out_status,
  input  logic                               cfg_we,
  input  logic [4:0]                         cfg_wdata
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = T_FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  bpe_pkg::state_t    state_r, state_nxt;
  logic [4:0]         point_count_r;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      s_r, s_nxt;
  logic [TW-1:0]      t_r, t_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [bpe_pkg::COORD_W-1:0] res_x_r, res_x_nxt;
  logic signed [bpe_pkg::COORD_W-1:0] res_y_r, res_y_nxt;
  logic [1:0]         status_r, status_nxt;
  bpe_pkg::cell_ctl_t ctl;

  logic [CW-1:0]      n_eff;
  logic               accept;
  logic               idx_ok;

  logic signed [bpe_pkg::COORD_W-1:0] w_x [MAX_POINTS];
  logic signed [bpe_pkg::COORD_W-1:0] w_y [MAX_POINTS];
  logic signed [bpe_pkg::COORD_W-1:0] lerp_x;
  logic signed [bpe_pkg::COORD_W-1:0] lerp_y;

  assign busy   = (state_r != bpe_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign n_eff  = ({27'd0, point_count_r} > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                           : CW'(point_count_r);
  assign idx_ok = ({{(bpe_pkg::IDX_W-4){1'b0}}, in_index} < bpe_pkg::IDX_W'(n_eff));

  // working ring
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic signed [bpe_pkg::COORD_W-1:0] rx;
    logic signed [bpe_pkg::COORD_W-1:0] ry;
    if (i < MAX_POINTS - 1) begin : g_mid
      assign rx = w_x[i+1];
      assign ry = w_y[i+1];
    end else begin : g_end
      assign rx = w_x[i];
      assign ry = w_y[i];
    end
    bpe_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .right_x(rx),
      .right_y(ry),
      .fb_x   (lerp_x),
      .fb_y   (lerp_y),
      .w_x    (w_x[i]),
      .w_y    (w_y[i])
    );
  end

  bpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lerp_x (
    .a(w_x[0]), .b(w_x[1]), .t(t_r), .p(lerp_x)
  );

  bpe_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lerp_y (
    .a(w_y[0]), .b(w_y[1]), .t(t_r), .p(lerp_y)
  );

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    out_valid_nxt = 1'b0;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    status_nxt    = status_r;
    ctl.wr_en     = 1'b0;
    ctl.wr_idx    = in_index;
    ctl.wr_x      = in_point_x;
    ctl.wr_y      = in_point_y;
    ctl.load      = 1'b0;
    ctl.shift     = 1'b0;
    ctl.wrap_idx  = bpe_pkg::IDX_W'(k_r - CW'(1));
    case (state_r)
      bpe_pkg::ST_IDLE: begin
        if (accept) begin
          res_x_nxt = '0;
          res_y_nxt = '0;
          if (in_func == bpe_pkg::FUNC_WRITE) begin
            out_valid_nxt = 1'b1;
            ctl.wr_en     = idx_ok;
            status_nxt    = idx_ok ? bpe_pkg::STAT_OK : bpe_pkg::STAT_BAD_INDEX;
          end else if (in_t_param > T_ONE) begin
            out_valid_nxt = 1'b1;
            status_nxt    = bpe_pkg::STAT_T_RANGE;
          end else if (n_eff < CW'(bpe_pkg::MIN_POINTS)) begin
            out_valid_nxt = 1'b1;
            status_nxt    = bpe_pkg::STAT_FEW_POINTS;
          end else begin
            ctl.load  = 1'b1;
            t_nxt     = in_t_param;
            k_nxt     = n_eff;
            s_nxt     = '0;
            state_nxt = bpe_pkg::ST_RUN;
          end
        end
      end
      bpe_pkg::ST_RUN: begin
        ctl.shift = 1'b1;
        if (k_r == CW'(bpe_pkg::MIN_POINTS)) begin
          out_valid_nxt = 1'b1;
          res_x_nxt     = lerp_x;
          res_y_nxt     = lerp_y;
          status_nxt    = bpe_pkg::STAT_OK;
          state_nxt     = bpe_pkg::ST_IDLE;
        end else if (s_r == k_r - CW'(1)) begin
          // drop the stale head, next level
          k_nxt = k_r - CW'(1);
          s_nxt = '0;
        end else begin
          s_nxt = s_r + CW'(1);
        end
      end
      default: begin
        state_nxt = bpe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bpe_pkg::ST_IDLE;
      point_count_r <= '0;
      out_valid_r   <= 1'b0;
      k_r           <= '0;
      s_r           <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      s_r         <= s_nxt;
      if (cfg_we) begin
        point_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    res_x_r  <= res_x_nxt;
    res_y_r  <= res_y_nxt;
    status_r <= status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_result_x = res_x_r;
  assign out_result_y = res_y_r;
  assign out_status   = status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != bpe_pkg::STAT_OK) |-> (res_x_r == '0) && (res_y_r == '0))
    else $error("error result carries nonzero coordinates");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpe_pkg::ST_RUN) |->
      (k_r >= CW'(bpe_pkg::MIN_POINTS)) && (k_r <= CW'(MAX_POINTS)))
    else $error("level size out of range");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpe_pkg::ST_RUN) |-> (s_r < k_r))
    else $error("step counter past level size");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid_r && (status_r == bpe_pkg::STAT_OK))
    else $error("evaluation ended without an ok result");

endmodule
